### hdl/assert_macros.svh
// Assertion macros used by the checker file of the traffic light block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while the reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tlc_pkg.sv
// Shared types, constants and the seven-segment decode of the traffic light block.
// No dependencies; used by tlc_csr, tlc_side and the top level of the block.
package tlc_pkg;

   localparam int TIME_W = 7;
   localparam int LAMP_W = 3;
   localparam int SEG_W  = 8;

   localparam logic [TIME_W-1:0] RESET_RED    = 7'd15;
   localparam logic [TIME_W-1:0] RESET_YELLOW = 7'd2;
   localparam logic [TIME_W-1:0] RESET_GREEN  = RESET_RED - RESET_YELLOW - 7'd1;

   localparam logic [LAMP_W-1:0] LAMP_GREEN  = 3'd3;
   localparam logic [LAMP_W-1:0] LAMP_YELLOW = 3'd5;
   localparam logic [LAMP_W-1:0] LAMP_RED    = 3'd6;
   localparam logic [LAMP_W-1:0] LAMP_OFF    = 3'd7;

   localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

   // Multiply by 205 and shift by 11 gives count / 10 for all 7-bit counts.
   localparam int DIV10_MUL    = 205;
   localparam int DIV10_SHIFT  = 11;
   localparam int DIV10_PROD_W = TIME_W + 8;
   localparam int DIGIT_W      = 4;

   typedef enum logic [0:0] {
      REG_RED_TIME    = 1'b0,
      REG_YELLOW_TIME = 1'b1
   } tlc_reg_type;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } tlc_phase_type;

   typedef struct packed {
      logic [TIME_W-1:0] red;
      logic [TIME_W-1:0] yellow;
      logic [TIME_W-1:0] green;
   } tlc_times_type;

   // Reload time and lamp code of each phase, indexed by phase code.
   typedef struct packed {
      logic [2:0][TIME_W-1:0] reload;
      logic [2:0][LAMP_W-1:0] lamp;
   } tlc_side_cfg_type;

   function automatic logic [SEG_W-1:0] tlc_seg(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] pattern;
      case (digit)
         4'd0:    pattern = 8'hC0;
         4'd1:    pattern = 8'hF9;
         4'd2:    pattern = 8'hA4;
         4'd3:    pattern = 8'hB0;
         4'd4:    pattern = 8'h99;
         4'd5:    pattern = 8'h92;
         4'd6:    pattern = 8'h83;
         4'd7:    pattern = 8'hF8;
         4'd8:    pattern = 8'h80;
         4'd9:    pattern = 8'h90;
         default: pattern = SEG_BLANK;
      endcase
      return pattern;
   endfunction

endpackage

### hdl/tlc_csr.sv
// Timing registers of the traffic light block and the derived green time.
// Depends on tlc_pkg.
module tlc_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [tlc_pkg::TIME_W-1:0] csr_wdata,
   output tlc_pkg::tlc_times_type     times
);

   logic [tlc_pkg::TIME_W-1:0] red_ff, red_in;
   logic [tlc_pkg::TIME_W-1:0] yellow_ff, yellow_in;

   always_comb begin
      red_in    = red_ff;
      yellow_in = yellow_ff;
      if (csr_we) begin
         unique case (tlc_pkg::tlc_reg_type'(csr_index))
            tlc_pkg::REG_RED_TIME:    red_in    = csr_wdata;
            tlc_pkg::REG_YELLOW_TIME: yellow_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff    <= tlc_pkg::RESET_RED;
         yellow_ff <= tlc_pkg::RESET_YELLOW;
      end else begin
         red_ff    <= red_in;
         yellow_ff <= yellow_in;
      end
   end

   // Green saturates at zero when yellow is not shorter than red.
   always_comb begin
      times.red    = red_ff;
      times.yellow = yellow_ff;
      times.green  = (red_ff > yellow_ff) ? (red_ff - yellow_ff - 7'd1) : '0;
   end

endmodule

### hdl/tlc_side.sv
// One approach of the traffic light: phase, countdown, lamps and two display digits.
// Depends on tlc_pkg.
module tlc_side (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [tlc_pkg::TIME_W-1:0]       count_init,
   input  tlc_pkg::tlc_side_cfg_type        cfg,
   output logic [tlc_pkg::LAMP_W-1:0]       lamps,
   output logic [tlc_pkg::SEG_W-1:0]        tens_seg,
   output logic [tlc_pkg::SEG_W-1:0]        ones_seg
);

   tlc_pkg::tlc_phase_type     phase_ff, phase_in;
   logic [tlc_pkg::TIME_W-1:0] count_ff, count_in;
   logic [tlc_pkg::LAMP_W-1:0] lamps_ff, lamps_in;
   logic [tlc_pkg::SEG_W-1:0]  tens_ff, tens_in;
   logic [tlc_pkg::SEG_W-1:0]  ones_ff, ones_in;
   logic                       live;

   logic [tlc_pkg::DIV10_PROD_W-1:0] product;
   logic [tlc_pkg::DIGIT_W-1:0]      tens_digit;
   logic [tlc_pkg::DIGIT_W-1:0]      ones_digit;
   logic [tlc_pkg::TIME_W-1:0]       tens_times_ten;

   // Next phase and count.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      live     = 1'b0;
      if (step) begin
         unique case (phase_ff)
            tlc_pkg::PHASE_FIRST: begin
               live = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - 7'd1;
               end else begin
                  phase_in = tlc_pkg::PHASE_SECOND;
                  count_in = cfg.reload[1];
               end
            end
            tlc_pkg::PHASE_SECOND: begin
               live = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - 7'd1;
               end else begin
                  phase_in = tlc_pkg::PHASE_THIRD;
                  count_in = cfg.reload[2];
               end
            end
            tlc_pkg::PHASE_THIRD: begin
               live = 1'b1;
               if (count_ff != '0) begin
                  count_in = count_ff - 7'd1;
               end else begin
                  phase_in = tlc_pkg::PHASE_FIRST;
                  count_in = cfg.reload[0];
               end
            end
            default: ;
         endcase
      end
   end

   // On a step, lamps and digits follow the new phase and count; otherwise they hold.
   always_comb begin
      product        = tlc_pkg::DIV10_PROD_W'(count_in)
                       * tlc_pkg::DIV10_PROD_W'(tlc_pkg::DIV10_MUL);
      tens_digit     = tlc_pkg::DIGIT_W'(product >> tlc_pkg::DIV10_SHIFT);
      tens_times_ten = tlc_pkg::TIME_W'(tens_digit) * 7'd10;
      ones_digit     = tlc_pkg::DIGIT_W'(count_in - tens_times_ten);
      lamps_in = lamps_ff;
      tens_in  = tens_ff;
      ones_in  = ones_ff;
      if (live) begin
         unique case (phase_in)
            tlc_pkg::PHASE_FIRST:  lamps_in = cfg.lamp[0];
            tlc_pkg::PHASE_SECOND: lamps_in = cfg.lamp[1];
            tlc_pkg::PHASE_THIRD:  lamps_in = cfg.lamp[2];
            default:               lamps_in = lamps_ff;
         endcase
         tens_in = tlc_pkg::tlc_seg(tens_digit);
         ones_in = tlc_pkg::tlc_seg(ones_digit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tlc_pkg::PHASE_FIRST;
         count_ff <= count_init;
         lamps_ff <= tlc_pkg::LAMP_OFF;
         tens_ff  <= tlc_pkg::SEG_BLANK;
         ones_ff  <= tlc_pkg::SEG_BLANK;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         lamps_ff <= lamps_in;
         tens_ff  <= tens_in;
         ones_ff  <= ones_in;
      end
   end

   assign lamps    = lamps_ff;
   assign tens_seg = tens_ff;
   assign ones_seg = ones_ff;

endmodule

### hdl/two_way_traffic_light_countdown.sv
// Top level of the two-approach traffic light with countdown display.
// Depends on tlc_pkg, tlc_csr and tlc_side.
//
//   Channel   Direction   Beat contents
//   req_      in          tick
//   rsp_      out         lamps and two digits of each approach
//   csr_      in          red_time (index 0), yellow_time (index 1)
//
// Each request beat yields one response beat in the next cycle; one beat per cycle while rsp_tready allows.
// The display registers of both approaches are the response register itself.
// req_tready is high whenever the response register is empty or being taken.
// Reset is synchronous; until the first tick lamps read all off and digits blank.
module two_way_traffic_light_countdown (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,  // [0] tick
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // [2:0] first_lamps, [10:3] first_tens_seg, [18:11] first_ones_seg,
   // [21:19] second_lamps, [29:22] second_tens_seg, [37:30] second_ones_seg
   output logic [39:0]                rsp_tdata,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [tlc_pkg::TIME_W-1:0] csr_wdata
);

   tlc_pkg::tlc_times_type    times;
   tlc_pkg::tlc_side_cfg_type first_cfg;
   tlc_pkg::tlc_side_cfg_type second_cfg;

   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic step;

   logic [tlc_pkg::LAMP_W-1:0] first_lamps, second_lamps;
   logic [tlc_pkg::SEG_W-1:0]  first_tens, first_ones, second_tens, second_ones;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign step       = accept && req_tdata[0];

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   tlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .times     (times)
   );

   always_comb begin
      first_cfg.reload[0]  = times.green;
      first_cfg.reload[1]  = times.yellow;
      first_cfg.reload[2]  = times.red;
      first_cfg.lamp[0]    = tlc_pkg::LAMP_GREEN;
      first_cfg.lamp[1]    = tlc_pkg::LAMP_YELLOW;
      first_cfg.lamp[2]    = tlc_pkg::LAMP_RED;
      second_cfg.reload[0] = times.red;
      second_cfg.reload[1] = times.green;
      second_cfg.reload[2] = times.yellow;
      second_cfg.lamp[0]   = tlc_pkg::LAMP_RED;
      second_cfg.lamp[1]   = tlc_pkg::LAMP_GREEN;
      second_cfg.lamp[2]   = tlc_pkg::LAMP_YELLOW;
   end

   tlc_side u_first (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .count_init (tlc_pkg::RESET_GREEN),
      .cfg        (first_cfg),
      .lamps      (first_lamps),
      .tens_seg   (first_tens),
      .ones_seg   (first_ones)
   );

   tlc_side u_second (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .count_init (tlc_pkg::RESET_RED),
      .cfg        (second_cfg),
      .lamps      (second_lamps),
      .tens_seg   (second_tens),
      .ones_seg   (second_ones)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, second_ones, second_tens, second_lamps,
                        first_ones, first_tens, first_lamps};

endmodule

### hdl/tlc_checker.sv
// Port-level checks of the traffic light top level, attached by a bind below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tlc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_tvalid, "response valid after reset")
   `ASSERT_RST(a_stall_holds, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "stalled response beat changed")
   `ASSERT_RST(a_beat_follows, clock, reset,
      req_tvalid && req_tready |=> rsp_tvalid,
      "request beat without response beat")
   `ASSERT_RST(a_ready_when_empty, clock, reset,
      !rsp_tvalid |-> req_tready,
      "request stalled with empty response register")
   `ASSERT_RST(a_one_lamp, clock, reset,
      rsp_tvalid |-> ($countones(rsp_tdata[2:0]) >= 2 && $countones(rsp_tdata[21:19]) >= 2),
      "more than one lamp lit on an approach")

endmodule

bind two_way_traffic_light_countdown tlc_checker u_tlc_checker (.*);
